FILE: rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes for the stack machine executor: instruction fields,
// primitive numbers, status codes and the decoded operation passed from the
// front end to the execution engine.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IMM_W    = 30;
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 11;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // instruction types
  localparam logic [TYPE_W-1:0] TYPE_PUSH     = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_PRIM     = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_PUSH_NEG = 2'd2;
  localparam logic [TYPE_W-1:0] TYPE_BAD      = 2'd3;

  // primitive numbers
  localparam logic [IMM_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [IMM_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [IMM_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [IMM_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [IMM_W-1:0] PRIM_DIV  = 30'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd5;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd7;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_HALT,
    OP_BAD_TYPE,
    OP_BAD_PRIM,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef struct packed {
    op_e               kind;
    logic [DATA_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   top;
    logic [DEPTH_W-1:0]  depth;
    logic                stopped;
  } result_t;

endpackage

FILE: rtl/core/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/smx_front.sv
// ----------------------------------------------------------------------------
// smx_front
// Input side: takes instruction beats and classifies each into a decoded
// operation with its push value, then hands it to the operation queue.
// ----------------------------------------------------------------------------
module smx_front
  import smx_pkg::*;
(
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [DATA_W-1:0] instruction_i,
  input  logic              queue_full_i,
  output logic              queue_push_o,
  output op_t               queue_op_o
);

  logic [TYPE_W-1:0] inst_type;
  logic [IMM_W-1:0]  imm;
  logic [DATA_W-1:0] imm_ext;

  assign inst_type = instruction_i[DATA_W-1 -: TYPE_W];
  assign imm       = instruction_i[IMM_W-1:0];
  assign imm_ext   = {{(DATA_W-IMM_W){1'b0}}, imm};

  always_comb begin
    queue_op_o.value = imm_ext;
    queue_op_o.kind  = OP_BAD_TYPE;
    case (inst_type)
      TYPE_PUSH: begin
        queue_op_o.kind = OP_PUSH;
      end
      TYPE_PUSH_NEG: begin
        queue_op_o.kind  = OP_PUSH;
        queue_op_o.value = DATA_W'(0) - imm_ext;
      end
      TYPE_PRIM: begin
        case (imm)
          PRIM_HALT: queue_op_o.kind = OP_HALT;
          PRIM_ADD:  queue_op_o.kind = OP_ADD;
          PRIM_SUB:  queue_op_o.kind = OP_SUB;
          PRIM_MUL:  queue_op_o.kind = OP_MUL;
          PRIM_DIV:  queue_op_o.kind = OP_DIV;
          default:   queue_op_o.kind = OP_BAD_PRIM;
        endcase
      end
      default: begin
        queue_op_o.kind = OP_BAD_TYPE;
      end
    endcase
  end

  assign in_stall_o   = queue_full_i;
  assign queue_push_o = in_valid_i && !queue_full_i;

endmodule

FILE: rtl/core/smx_queue.sv
// ----------------------------------------------------------------------------
// smx_queue
// Short FIFO of decoded operations between the front end and the engine.
// ----------------------------------------------------------------------------
module smx_queue
  import smx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t                 entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

FILE: rtl/core/smx_div.sv
// ----------------------------------------------------------------------------
// smx_div
// Signed 32-bit divider truncating toward zero, one quotient bit per cycle
// (restoring division on magnitudes, sign applied at the output).
// ----------------------------------------------------------------------------
module smx_div
  import smx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DATA_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [DATA_W-1:0] quo_q;
  logic [DATA_W-1:0] dsr_q;
  logic              neg_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   shifted;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[DATA_W-1] ? DATA_W'(0) - dividend_i : dividend_i;
      dsr_q <= divisor_i[DATA_W-1] ? DATA_W'(0) - divisor_i : divisor_i;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? DATA_W'(0) - quo_q : quo_q;

endmodule

FILE: rtl/core/smx_exec.sv
// ----------------------------------------------------------------------------
// smx_exec
// Execution engine: keeps the top of stack in a register and the rest in a
// RAM, runs each decoded operation and loads the result register.
// ----------------------------------------------------------------------------
module smx_exec
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  op_t     q_op_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  localparam int unsigned PtrW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam logic [PtrW-1:0] FullPtr = PtrW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [DEPTH_W-1:0] to_depth(input logic [PtrW-1:0] p);
    logic [PtrW+DEPTH_W-1:0] ext;
    ext = {{DEPTH_W{1'b0}}, p};
    return ext[DEPTH_W-1:0];
  endfunction

  logic [1:0]          state_q, state_d;
  logic [PtrW-1:0]     sp_q, sp_d;
  logic                halt_q, halt_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   tos_q, tos_d;
  logic [DATA_W-1:0]   res_q, res_d;
  op_e                 kind_q, kind_d;
  result_t             out_q, out_d;

  logic [PtrW-1:0]     sp_m1;
  logic [PtrW-1:0]     sp_m2;
  logic [PtrW-1:0]     sp_p1;
  logic [DATA_W-1:0]   top_now;
  logic                out_free;
  logic                err;
  logic [STATUS_W-1:0] err_code;

  logic                ram_we;
  logic [DATA_W-1:0]   ram_rdata;
  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_quot;

  assign sp_m1    = sp_q - 1'b1;
  assign sp_m2    = sp_q - PtrW'(2);
  assign sp_p1    = sp_q + 1'b1;
  assign top_now  = (sp_q == '0) ? '0 : tos_q;
  assign out_free = !out_valid_q || !out_stall_i;

  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_m1[AddrW-1:0]),
    .wdata_i (tos_q),
    .raddr_i (sp_m2[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ram_rdata),
    .divisor_i  (tos_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    halt_d      = halt_q;
    tos_d       = tos_q;
    res_d       = res_q;
    kind_d      = kind_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    err         = 1'b0;
    err_code    = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (halt_q) begin
            out_valid_d   = 1'b1;
            out_d.status  = ST_STOPPED;
            out_d.top     = top_now;
            out_d.depth   = to_depth(sp_q);
            out_d.stopped = 1'b1;
          end else begin
            case (q_op_i.kind)
              OP_PUSH: begin
                if (sp_q == FullPtr) begin
                  err      = 1'b1;
                  err_code = ST_OVERFLOW;
                end else begin
                  ram_we        = (sp_q != '0);
                  tos_d         = q_op_i.value;
                  sp_d          = sp_p1;
                  out_valid_d   = 1'b1;
                  out_d.status  = ST_OK;
                  out_d.top     = q_op_i.value;
                  out_d.depth   = to_depth(sp_p1);
                  out_d.stopped = 1'b0;
                end
              end
              OP_HALT: begin
                err      = 1'b1;
                err_code = ST_HALT;
              end
              OP_BAD_TYPE: begin
                err      = 1'b1;
                err_code = ST_BAD_TYPE;
              end
              OP_BAD_PRIM: begin
                err      = 1'b1;
                err_code = ST_BAD_PRIM;
              end
              default: begin
                if (sp_q < PtrW'(2)) begin
                  err      = 1'b1;
                  err_code = ST_UNDERFLOW;
                end else if (q_op_i.kind == OP_DIV && tos_q == '0) begin
                  err      = 1'b1;
                  err_code = ST_DIV_ZERO;
                end else begin
                  kind_d  = q_op_i.kind;
                  state_d = S_READ;
                end
              end
            endcase
            if (err) begin
              halt_d        = 1'b1;
              out_valid_d   = 1'b1;
              out_d.status  = err_code;
              out_d.top     = top_now;
              out_d.depth   = to_depth(sp_q);
              out_d.stopped = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        state_d = S_DONE;
        case (kind_q)
          OP_ADD: res_d = ram_rdata + tos_q;
          OP_SUB: res_d = ram_rdata - tos_q;
          OP_MUL: res_d = ram_rdata * tos_q;
          default: begin
            div_start = 1'b1;
            state_d   = S_DIVW;
          end
        endcase
      end
      S_DIVW: begin
        if (div_done) begin
          res_d   = div_quot;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          tos_d         = res_q;
          sp_d          = sp_m1;
          out_valid_d   = 1'b1;
          out_d.status  = ST_OK;
          out_d.top     = res_q;
          out_d.depth   = to_depth(sp_m1);
          out_d.stopped = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q  <= tos_d;
    res_q  <= res_d;
    kind_q <= kind_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/stack_machine_executor.sv
// ----------------------------------------------------------------------------
// stack_machine_executor
// Stack-machine instruction executor: pushes, negated pushes and the
// halt/add/sub/mul/div primitives on a RAM-backed value stack, one result
// beat per instruction beat.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o | instruction_i
//   out     | output    | out_valid_o / out_stall_i | status_o top_value_o depth_o
//           |           |                        | stopped_o
//
// Pushes, halt, faults and instructions after a stop are answered in S_IDLE.
// Add, sub and mul pass the read and done states, as second-from-top comes from
// the stack RAM's registered read port; div waits between them on the divider,
// one quotient bit per cycle. Each instruction starts only when the previous one
// has updated the stack pointer; a two-entry queue keeps taking input beats
// meanwhile. Reset clears the stack pointer and the stop flag; no clearing pass.
// ----------------------------------------------------------------------------
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [DATA_W-1:0]         instruction_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [DATA_W-1:0]  top_value_o,
  output logic [DEPTH_W-1:0]        depth_o,
  output logic                      stopped_o
);

  logic    queue_full;
  logic    queue_push;
  op_t     front_op;
  logic    queue_valid;
  logic    queue_pop;
  op_t     queue_op;
  result_t result;

  smx_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .instruction_i (instruction_i),
    .queue_full_i  (queue_full),
    .queue_push_o  (queue_push),
    .queue_op_o    (front_op)
  );

  smx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (queue_push),
    .op_i    (front_op),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .op_o    (queue_op)
  );

  smx_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_op_i      (queue_op),
    .q_pop_o     (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (result)
  );

  assign status_o    = result.status;
  assign top_value_o = $signed(result.top);
  assign depth_o     = result.depth;
  assign stopped_o   = result.stopped;

endmodule

FILE: rtl/core/smx_checker.sv
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks for the stack machine executor, bound to the top level.
// ----------------------------------------------------------------------------
module smx_checker
  import smx_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [STATUS_W-1:0]      status_o,
  input logic signed [DATA_W-1:0] top_value_o,
  input logic [DEPTH_W-1:0]       depth_o,
  input logic                     stopped_o
);

  logic seen_stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_stop_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && stopped_o) begin
      seen_stop_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(top_value_o) && $stable(depth_o) && $stable(stopped_o))
    else $error("out beat changed while stalled");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_stop_q |-> stopped_o && status_o == ST_STOPPED)
    else $error("beat after stop is not reported as stopped");

  a_ok_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_OK) == !stopped_o))
    else $error("status and stopped flag disagree");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && depth_o == '0 |-> top_value_o == '0)
    else $error("nonzero top value on empty stack");

endmodule

bind stack_machine_executor smx_checker u_smx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .top_value_o (top_value_o),
  .depth_o     (depth_o),
  .stopped_o   (stopped_o)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stack_machine_executor. A scoreboard class keeps a
// shadow stack, predicts status, top, depth and stop flag for every accepted
// instruction beat and checks each result beat in order. The stimulus runs
// directed arithmetic corner cases first. It follows with random push and
// arithmetic sequences that keep the machine running, under random idling and
// one long output hold-off. It ends with one randomly chosen stopping case
// and twenty more beats that must come back as stopped.
// ----------------------------------------------------------------------------
module tb;
  import smx_pkg::*;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned RAND_BEATS  = 800;
  localparam int unsigned SEG_BEATS   = 100;
  localparam int unsigned QUIET_BEAT  = 650;
  localparam int unsigned HOLD_BEAT   = 300;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned MAX_SHOWN   = 10;

  logic                     clk = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic [DATA_W-1:0]        instruction = '0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic                     stopped;

  int unsigned in_gap_pct = 0;
  int unsigned out_gap_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned in_stall_cycles = 0;

  class stack_scoreboard;
    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    int unsigned         sp;
    bit                  halted;
    result_t             want_q [$];
    int unsigned         errors;
    int unsigned         accepted;
    int unsigned         results;
    int unsigned         arith_ops;
    int unsigned         peak_depth;
    logic [STATUS_W-1:0] stop_status = ST_OK;

    function logic [DATA_W-1:0] top_word();
      return (sp > 0) ? stack_mem[sp-1] : '0;
    endfunction

    function void note_input(logic [DATA_W-1:0] instr);
      logic [TYPE_W-1:0]        kind;
      logic [IMM_W-1:0]         imm;
      logic [DATA_W-1:0]        word;
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
      logic signed [DATA_W-1:0] res;
      logic [STATUS_W-1:0]      st;
      result_t                  want;
      kind = instr[DATA_W-1 -: TYPE_W];
      imm  = instr[IMM_W-1:0];
      word = DATA_W'(imm);
      st   = ST_OK;
      res  = '0;
      accepted++;
      if (halted) begin
        st = ST_STOPPED;
      end else begin
        case (kind)
          TYPE_PUSH, TYPE_PUSH_NEG: begin
            if (sp >= STACK_DEPTH) begin
              st = ST_OVERFLOW;
            end else begin
              stack_mem[sp] = (kind == TYPE_PUSH) ? word : (DATA_W'(0) - word);
              sp++;
            end
          end
          TYPE_PRIM: begin
            if (imm == PRIM_HALT) begin
              st = ST_HALT;
            end else if (imm > PRIM_DIV) begin
              st = ST_BAD_PRIM;
            end else if (sp < 2) begin
              st = ST_UNDERFLOW;
            end else begin
              lhs = stack_mem[sp-2];
              rhs = stack_mem[sp-1];
              case (imm)
                PRIM_ADD: res = lhs + rhs;
                PRIM_SUB: res = lhs - rhs;
                PRIM_MUL: res = lhs * rhs;
                default: begin
                  // wrap most negative / -1 explicitly
                  if (rhs == 0) st = ST_DIV_ZERO;
                  else if (rhs == -1) res = -lhs;
                  else res = lhs / rhs;
                end
              endcase
              if (st == ST_OK) begin
                stack_mem[sp-2] = res;
                sp--;
                arith_ops++;
              end
            end
          end
          default: st = ST_BAD_TYPE;
        endcase
        if (st != ST_OK) begin
          halted      = 1'b1;
          stop_status = st;
        end
      end
      if (sp > peak_depth) peak_depth = sp;
      want.status  = st;
      want.top     = top_word();
      want.depth   = DEPTH_W'(sp);
      want.stopped = halted;
      want_q.push_back(want);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] top,
                               logic [DEPTH_W-1:0] dep, logic stp);
      result_t want;
      results++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: result beat with nothing pending: status %0d top %0d depth %0d",
                   $time, st, $signed(top), dep);
        return;
      end
      want = want_q.pop_front();
      if (st !== want.status || top !== want.top || dep !== want.depth ||
          stp !== want.stopped) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: mismatch (exp/got) status %0d/%0d top %0d/%0d depth %0d/%0d stop %0b/%0b",
                   $time, want.status, st, $signed(want.top), $signed(top),
                   want.depth, dep, want.stopped, stp);
      end
    endfunction
  endclass

  stack_scoreboard sb;

  stack_machine_executor #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .instruction_i(instruction),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .top_value_o  (top_value),
    .depth_o      (depth),
    .stopped_o    (stopped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // note the input beat first so a same-edge result finds it
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_input(instruction);
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid && !out_stall) sb.check_result(status, top_value, depth, stopped);
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < out_gap_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_instr(input logic [DATA_W-1:0] instr);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    instruction <= instr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic push_value(input bit neg, input logic [IMM_W-1:0] imm);
    send_instr({neg ? TYPE_PUSH_NEG : TYPE_PUSH, imm});
  endtask

  task automatic run_prim(input logic [IMM_W-1:0] prim);
    send_instr({TYPE_PRIM, prim});
  endtask

  function automatic logic [IMM_W-1:0] pick_imm();
    case ($urandom_range(0, 3))
      0:       return IMM_W'($urandom_range(0, 15));
      1:       return $urandom_range(0, 1) ? '1 : IMM_W'(1) << $urandom_range(0, IMM_W-1);
      default: return IMM_W'($urandom);
    endcase
  endfunction

  task automatic random_step(input int unsigned push_pct);
    logic [IMM_W-1:0] prim;
    if (sb.sp < 2 || (sb.sp < STACK_DEPTH && $urandom_range(0, 99) < push_pct)) begin
      push_value(1'($urandom_range(0, 1)), pick_imm());
    end else begin
      prim = IMM_W'($urandom_range(PRIM_ADD, PRIM_DIV));
      if (prim == PRIM_DIV && sb.top_word() == '0) prim = PRIM_SUB;
      run_prim(prim);
    end
  endtask

  initial begin : stimulus
    logic [STATUS_W-1:0] stop_kinds [6];
    logic [STATUS_W-1:0] last_fault;
    int unsigned         push_pct;
    int unsigned         gap_choice [3];
    stop_kinds = '{ST_HALT, ST_BAD_TYPE, ST_BAD_PRIM, ST_DIV_ZERO, ST_UNDERFLOW, ST_OVERFLOW};
    gap_choice = '{0, 15, 35};
    push_pct   = 50;
    sb = new();
    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // wrapping add and multiply, zero product, most negative / -1, truncating divide
    push_value(1'b0, 30'h3FFFFFFF);
    push_value(1'b0, 30'h3FFFFFFF);
    run_prim(PRIM_ADD);
    push_value(1'b0, 30'h3FFFFFFF);
    run_prim(PRIM_ADD);
    push_value(1'b1, 30'h3FFFFFFF);
    run_prim(PRIM_SUB);
    push_value(1'b1, 30'h0);
    run_prim(PRIM_MUL);
    push_value(1'b0, 30'h20000000);
    push_value(1'b0, 30'h4);
    run_prim(PRIM_MUL);
    push_value(1'b1, 30'h1);
    run_prim(PRIM_DIV);
    push_value(1'b1, 30'h7);
    push_value(1'b0, 30'h2);
    run_prim(PRIM_DIV);
    run_prim(PRIM_SUB);
    push_value(1'b0, 30'h15555555);
    push_value(1'b1, 30'h2AAAAAAA);
    run_prim(PRIM_MUL);
    run_prim(PRIM_DIV);

    last_fault = stop_kinds[$urandom_range(0, 5)];

    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % SEG_BEATS == 0) begin
        push_pct    = $urandom_range(35, 70);
        in_gap_pct  = gap_choice[$urandom_range(0, 2)];
        out_gap_pct = gap_choice[$urandom_range(0, 2)];
        // build the stack up ahead of an overflow ending
        if (last_fault == ST_OVERFLOW) push_pct = 100;
      end
      if (n == HOLD_BEAT) begin
        hold_req   = 1'b1;
        in_gap_pct = 0;
      end
      if (n >= QUIET_BEAT) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      random_step(push_pct);
    end

    case (last_fault)
      ST_HALT:     run_prim(PRIM_HALT);
      ST_BAD_TYPE: send_instr({TYPE_BAD, IMM_W'($urandom)});
      ST_BAD_PRIM: run_prim(IMM_W'($urandom_range(PRIM_DIV + 1, 30'h3FFFFFFF)));
      ST_DIV_ZERO: begin
        if (sb.sp == 0) push_value(1'b0, pick_imm());
        push_value(1'($urandom_range(0, 1)), '0);
        run_prim(PRIM_DIV);
      end
      ST_UNDERFLOW: begin
        while (sb.sp >= 2) run_prim(IMM_W'($urandom_range(PRIM_ADD, PRIM_SUB)));
        run_prim(IMM_W'($urandom_range(PRIM_ADD, PRIM_DIV)));
      end
      default: begin
        while (sb.sp < STACK_DEPTH) push_value(1'($urandom_range(0, 1)), pick_imm());
        push_value(1'($urandom_range(0, 1)), pick_imm());
      end
    endcase
    // every beat after the stop must come back as stopped
    repeat (20) send_instr($urandom);
    in_valid <= 1'b0;

    for (int n = 0; n < 10000 && sb.want_q.size() != 0; n++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.want_q.size() != 0) begin
      sb.errors++;
      $display("%0d result beats never arrived", sb.want_q.size());
    end

    $display("Ran %0d instructions, %0d result beats, %0d arithmetic steps, peak depth %0d",
             sb.accepted, sb.results, sb.arith_ops, sb.peak_depth);
    $display("Stopped with status %0d; input stalled %0d cycles; %0d mismatches",
             sb.stop_status, in_stall_cycles, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Timed out waiting for result beats");
    $display("Test completed with failures");
    $finish;
  end

endmodule
